// File: src/hall_rotation_direction_check_core_defines.svh
// ----------------------------------------------------------------------------
// Hall rotation direction check - assertion macros
// Shared property wrappers for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef HALL_ROTATION_DIRECTION_CHECK_CORE_DEFINES_SVH
`define HALL_ROTATION_DIRECTION_CHECK_CORE_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define HRDC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HRDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define HRDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/hrdc_pkg.sv
// ----------------------------------------------------------------------------
// Hall rotation direction check - package
// Field widths, outcome codes, register indexes and a phase helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrdc_pkg;

  localparam int HALL_W      = 3;
  localparam int PHASE_W     = 3;
  localparam int TIME_W      = 16;
  localparam int MAP_W       = 24;
  localparam int OUTCOME_W   = 3;
  localparam int FLAG_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam int FLAG_HALL_BIT = 0;
  localparam int FLAG_DIR_BIT  = 1;

  localparam logic [PHASE_W-1:0] PHASE_MAX = 3'd5;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FORWARD  = 3'd0,
    OUT_BACKWARD = 3'd1,
    OUT_SLOW     = 3'd2,
    OUT_HALL_ERR = 3'd3,
    OUT_DIR_ERR  = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_MAP      = 2'd0,
    CFG_COUNTER_PERIOD = 2'd1,
    CFG_SLOW_THRESHOLD = 2'd2
  } cfg_index_t;

  // Next commutation phase, wrapping from the last phase back to zero.
  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] r;
    if (p == PHASE_MAX) begin
      r = '0;
    end else begin
      r = p + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: src/hrdc_history.sv
// ----------------------------------------------------------------------------
// Hall rotation direction check - history stage
// Maps each Hall state to a phase, picks the edge interval and shifts both
// into the phase and time history on every accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrdc_history #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_accept,
  input  logic [hrdc_pkg::HALL_W-1:0]                    hall_state,
  input  logic                                           capture_valid,
  input  logic [hrdc_pkg::TIME_W-1:0]                    capture_time,
  input  logic [hrdc_pkg::MAP_W-1:0]                     phase_map,
  input  logic [hrdc_pkg::TIME_W-1:0]                    counter_period,
  input  logic                                           advance,
  output logic                                           hist_valid,
  output logic [HISTORY_DEPTH-1:0][hrdc_pkg::PHASE_W-1:0] phase_hist,
  output logic [HISTORY_DEPTH-1:0][hrdc_pkg::TIME_W-1:0]  time_hist
);

  logic                                            valid_r, valid_nxt;
  logic [HISTORY_DEPTH-1:0][hrdc_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [HISTORY_DEPTH-1:0][hrdc_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic [4:0]                                      map_base;
  logic [hrdc_pkg::PHASE_W-1:0]                    edge_phase;
  logic [hrdc_pkg::TIME_W-1:0]                     edge_interval;

  always_comb begin
    map_base   = {2'b00, hall_state} * 5'd3;
    edge_phase = phase_map[map_base +: hrdc_pkg::PHASE_W];
    if (capture_valid && (capture_time != '0)) begin
      edge_interval = capture_time;
    end else begin
      edge_interval = counter_period - 16'd1;
    end

    phase_nxt = phase_r;
    time_nxt  = time_r;
    if (in_accept) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
        phase_nxt[i] = phase_r[i-1];
        time_nxt[i]  = time_r[i-1];
      end
      phase_nxt[0] = edge_phase;
      time_nxt[0]  = edge_interval;
    end

    if (in_accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= '0;
      time_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
      time_r  <= time_nxt;
    end
  end

  assign hist_valid = valid_r;
  assign phase_hist = phase_r;
  assign time_hist  = time_r;

endmodule

// File: src/hrdc_classify.sv
// ----------------------------------------------------------------------------
// Hall rotation direction check - classifier and result register
// Classifies the current history by fixed priority, updates the sticky
// error flags and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrdc_classify #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            hist_valid,
  input  logic [HISTORY_DEPTH-1:0][hrdc_pkg::PHASE_W-1:0] phase_hist,
  input  logic [HISTORY_DEPTH-1:0][hrdc_pkg::TIME_W-1:0]  time_hist,
  input  logic [hrdc_pkg::TIME_W-1:0]                     slow_threshold,
  input  logic                                            out_ready,
  output logic                                            advance,
  output logic                                            out_valid,
  output hrdc_pkg::outcome_t                              outcome,
  output logic [hrdc_pkg::FLAG_W-1:0]                     error_flags
);

  logic                            valid_r, valid_nxt;
  hrdc_pkg::outcome_t              outcome_r, outcome_nxt;
  logic [hrdc_pkg::FLAG_W-1:0]     flags_r, flags_nxt;
  logic                            bad_phase, slow, fwd, bwd;

  assign advance = hist_valid && (!valid_r || out_ready);

  always_comb begin
    bad_phase = 1'b0;
    slow      = 1'b0;
    fwd       = 1'b1;
    bwd       = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (phase_hist[i] > hrdc_pkg::PHASE_MAX) begin
        bad_phase = 1'b1;
      end
      if (time_hist[i] >= slow_threshold) begin
        slow = 1'b1;
      end
    end
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      if (phase_hist[i] != hrdc_pkg::next_phase(phase_hist[i+1])) begin
        fwd = 1'b0;
      end
      if (phase_hist[i+1] != hrdc_pkg::next_phase(phase_hist[i])) begin
        bwd = 1'b0;
      end
    end

    outcome_nxt = outcome_r;
    flags_nxt   = flags_r;
    if (advance) begin
      priority if (bad_phase) begin
        outcome_nxt = hrdc_pkg::OUT_HALL_ERR;
        flags_nxt[hrdc_pkg::FLAG_HALL_BIT] = 1'b1;
      end else if (slow) begin
        outcome_nxt = hrdc_pkg::OUT_SLOW;
      end else if (fwd) begin
        outcome_nxt = hrdc_pkg::OUT_FORWARD;
      end else if (bwd) begin
        outcome_nxt = hrdc_pkg::OUT_BACKWARD;
      end else begin
        outcome_nxt = hrdc_pkg::OUT_DIR_ERR;
        flags_nxt[hrdc_pkg::FLAG_DIR_BIT] = 1'b1;
      end
    end

    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      flags_r   <= '0;
      outcome_r <= hrdc_pkg::OUT_FORWARD;
    end else begin
      valid_r   <= valid_nxt;
      flags_r   <= flags_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign outcome     = outcome_r;
  assign error_flags = flags_r;

endmodule

// File: src/hall_rotation_direction_check_core.sv
// ----------------------------------------------------------------------------
// Hall rotation direction check core
// Checks Hall sensor edge events for sensor faults, slow rotation and the
// direction of rotation, with sticky error flags.
// ----------------------------------------------------------------------------
// One input beat is one Hall edge and gives exactly one result beat. The core
// takes a beat in every cycle unless the output stalls it; a result passes the
// history register, then the result register. Output back-pressure holds the
// result register; the input then stalls once the history stage is full too.
// The user must write configuration only while no beat is in flight; the core
// does not enforce this. The sticky error flags clear only on reset.
`timescale 1ns / 1ps
`include "hall_rotation_direction_check_core_defines.svh"

module hall_rotation_direction_check_core #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // [2:0] hall_state, [3] capture_valid, [19:4] capture_time, [23:20] zero
  input  logic [hrdc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] outcome, [4:3] error_flags, [7:5] zero
  output logic [hrdc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [hrdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [hrdc_pkg::MAP_W-1:0]                      phase_map_r;
  logic [hrdc_pkg::TIME_W-1:0]                     period_r;
  logic [hrdc_pkg::TIME_W-1:0]                     threshold_r;
  logic                                            in_accept;
  logic                                            advance;
  logic                                            hist_valid;
  logic [HISTORY_DEPTH-1:0][hrdc_pkg::PHASE_W-1:0] phase_hist;
  logic [HISTORY_DEPTH-1:0][hrdc_pkg::TIME_W-1:0]  time_hist;
  hrdc_pkg::outcome_t                              outcome;
  logic [hrdc_pkg::FLAG_W-1:0]                     error_flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_map_r <= '1;
      period_r    <= '1;
      threshold_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrdc_pkg::CFG_PHASE_MAP:      phase_map_r <= cfg_wdata;
        hrdc_pkg::CFG_COUNTER_PERIOD: period_r    <= cfg_wdata[hrdc_pkg::TIME_W-1:0];
        hrdc_pkg::CFG_SLOW_THRESHOLD: threshold_r <= cfg_wdata[hrdc_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !hist_valid || advance;
  assign in_accept = in_tvalid && in_tready;

  hrdc_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .hall_state    (in_tdata[2:0]),
    .capture_valid (in_tdata[3]),
    .capture_time  (in_tdata[19:4]),
    .phase_map     (phase_map_r),
    .counter_period(period_r),
    .advance       (advance),
    .hist_valid    (hist_valid),
    .phase_hist    (phase_hist),
    .time_hist     (time_hist)
  );

  hrdc_classify #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .hist_valid    (hist_valid),
    .phase_hist    (phase_hist),
    .time_hist     (time_hist),
    .slow_threshold(threshold_r),
    .out_ready     (out_tready),
    .advance       (advance),
    .out_valid     (out_tvalid),
    .outcome       (outcome),
    .error_flags   (error_flags)
  );

  assign out_tdata = {3'b000, error_flags, outcome};

  `HRDC_ASSERT_NEXT(a_hall_flag_sticky, error_flags[hrdc_pkg::FLAG_HALL_BIT], error_flags[hrdc_pkg::FLAG_HALL_BIT], "Hall error flag cleared outside reset")
  `HRDC_ASSERT_NEXT(a_dir_flag_sticky, error_flags[hrdc_pkg::FLAG_DIR_BIT], error_flags[hrdc_pkg::FLAG_DIR_BIT], "Direction error flag cleared outside reset")
  `HRDC_ASSERT_SAME(a_hall_outcome_flag, out_tvalid && (outcome == hrdc_pkg::OUT_HALL_ERR), error_flags[hrdc_pkg::FLAG_HALL_BIT], "Hall error result without its flag")
  `HRDC_ASSERT_SAME(a_dir_outcome_flag, out_tvalid && (outcome == hrdc_pkg::OUT_DIR_ERR), error_flags[hrdc_pkg::FLAG_DIR_BIT], "Direction error result without its flag")
  `HRDC_ASSERT_SAME(a_full_stall, hist_valid && out_tvalid && !out_tready, !in_tready, "Input taken while both stages are full and stalled")

endmodule
